>>> sv/mec_pkg.sv
// shared types, constants and helper functions for the escape-count block
package mec_pkg;

	localparam int FRAC_BITS   = 28;
	localparam int IN_FRAC     = 28;
	localparam int COUNT_WIDTH = 16;
	localparam int ADDR_W      = 3;

	localparam int UP_SHIFT = (FRAC_BITS >= IN_FRAC) ? FRAC_BITS - IN_FRAC : 0;
	localparam int DN_SHIFT = (FRAC_BITS < IN_FRAC) ? IN_FRAC - FRAC_BITS : 0;

	localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

	localparam logic [15:0] COUNT_MASK = 16'((64'd1 << COUNT_WIDTH) - 64'd1);

	localparam logic [15:0] MAX_ITER_RESET = 16'd4096;
	localparam logic [14:0] THRESH_RESET   = 15'd1000;

	localparam logic REG_MAX_ITER = 1'b0;
	localparam logic REG_THRESH   = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_MUL_AA,
		S_WAIT_AA,
		S_MUL_BB,
		S_WAIT_BB,
		S_MUL_AB,
		S_WAIT_AB,
		S_SUB_BB,
		S_SUB_C,
		S_DBL_AB,
		S_SUB_D,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [15:0] max_iterations;
		logic [14:0] escape_threshold;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic signed [63:0] x;
		logic signed [63:0] y;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic signed [63:0] prod;
	} mul_rsp_t;

	// q4.28 input to working format, floor rounding when narrowing
	function automatic logic signed [63:0] from_input(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return (w <<< UP_SHIFT) >>> DN_SHIFT;
	endfunction

	function automatic logic signed [63:0] threshold_fx(input logic [14:0] t);
		return signed'(64'(t) << FRAC_BITS);
	endfunction

endpackage

>>> sv/mec_point_if.sv
// input channel carrying one complex point
interface mec_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_real;
	logic signed [31:0] point_imag;

	modport source(output valid, point_real, point_imag, input ready);
	modport sink(input valid, point_real, point_imag, output ready);
endinterface

>>> sv/mec_result_if.sv
// output channel carrying one escape-count result
interface mec_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] iteration_count;
	logic        escaped;

	modport source(output valid, iteration_count, escaped, input ready);
	modport sink(input valid, iteration_count, escaped, output ready);
endinterface

>>> sv/mec_regs.sv
// apb configuration registers
module mec_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mec_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output mec_pkg::cfg_t               cfg
);
	import mec_pkg::*;

	logic [15:0] max_iter_q;
	logic [14:0] thresh_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RESET;
			thresh_q   <= THRESH_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_MAX_ITER: max_iter_q <= pwdata[15:0];
				REG_THRESH:   thresh_q   <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_ITER: prdata = {16'd0, max_iter_q};
			REG_THRESH:   prdata = {17'd0, thresh_q};
			default:      prdata = 32'd0;
		endcase
	end

	assign cfg.max_iterations   = max_iter_q;
	assign cfg.escape_threshold = thresh_q;

endmodule

>>> sv/mec_fxmul.sv
// shared saturating fixed-point multiplier, one 32x32 partial product per cycle
module mec_fxmul (
	input  logic              clk,
	input  logic              arst_n,
	input  mec_pkg::mul_req_t req,
	output mec_pkg::mul_rsp_t rsp
);
	import mec_pkg::*;

	localparam logic [2:0] STEP_LAST_MUL = 3'd3;
	localparam logic [2:0] STEP_LAST_ACC = 3'd4;
	localparam logic [2:0] STEP_POST     = 3'd5;

	logic               busy_q;
	logic [2:0]         step_q;
	logic               done_q;
	logic               neg_q;
	logic [63:0]        mx_q;
	logic [63:0]        my_q;
	logic [63:0]        pp_s1;
	logic [1:0]         sh_s1;
	logic [127:0]       acc_q;
	logic signed [63:0] prod_q;

	logic [31:0]        xh;
	logic [31:0]        yh;
	logic [63:0]        pp;
	logic [127:0]       addend;
	logic [63:0]        mag;
	logic               ovf;
	logic signed [63:0] post;

	// partial product order: lo*lo, lo*hi, hi*lo, hi*hi
	assign xh = step_q[1] ? mx_q[63:32] : mx_q[31:0];
	assign yh = step_q[0] ? my_q[63:32] : my_q[31:0];
	assign pp = 64'(xh) * 64'(yh);

	always_comb begin
		case (sh_s1)
			2'b00:   addend = {64'd0, pp_s1};
			2'b01:   addend = {32'd0, pp_s1, 32'd0};
			2'b10:   addend = {pp_s1, 64'd0};
			default: addend = 128'd0;
		endcase
	end

	assign ovf = |acc_q[127:64+FRAC_BITS];
	assign mag = acc_q[FRAC_BITS +: 64];

	always_comb begin
		if (ovf || mag[63]) begin
			post = neg_q ? SAT_MIN : SAT_MAX;
		end else if (neg_q) begin
			post = signed'(64'd0 - mag);
		end else begin
			post = signed'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == STEP_POST);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 3'd0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == STEP_POST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.x[63] != req.y[63];
			mx_q  <= req.x[63] ? 64'd0 - req.x : req.x;
			my_q  <= req.y[63] ? 64'd0 - req.y : req.y;
			acc_q <= 128'd0;
		end else if (busy_q) begin
			if (step_q <= STEP_LAST_MUL) begin
				pp_s1 <= pp;
				sh_s1 <= {step_q[1] & step_q[0], step_q[1] ^ step_q[0]};
			end
			if (step_q != 3'd0 && step_q <= STEP_LAST_ACC) begin
				acc_q <= acc_q + addend;
			end
			if (step_q == STEP_POST) begin
				prod_q <= post;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;

`ifndef NO_ASSERTIONS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("multiplier restarted while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("multiplier done held");
	a_done_after_post: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(step_q) == STEP_POST && $past(busy_q))
		else $error("multiplier done without post step");
`endif

endmodule

>>> sv/mec_seq.sv
// iteration sequencer with working registers and shared saturating adder
module mec_seq (
	input  logic              clk,
	input  logic              arst_n,
	mec_point_if.sink         pnt,
	mec_result_if.source      res,
	input  mec_pkg::cfg_t     cfg,
	output mec_pkg::mul_req_t mul_req,
	input  mec_pkg::mul_rsp_t mul_rsp
);
	import mec_pkg::*;

	seq_state_t state_q;
	seq_state_t state_d;

	logic signed [63:0] c_q;
	logic signed [63:0] d_q;
	logic signed [63:0] a_q;
	logic signed [63:0] b_q;
	logic signed [63:0] aa_q;
	logic signed [63:0] bb_q;
	logic signed [63:0] ab_q;
	logic signed [63:0] t_q;
	logic [15:0]        count_q;
	logic [15:0]        res_count_q;
	logic               esc_q;

	logic signed [63:0] op_x;
	logic signed [63:0] op_y;
	logic               op_sub;
	logic [64:0]        sum65;
	logic signed [63:0] sat_res;
	logic               limit_hit;
	logic               above_thr;
	logic               in_acc;

	assign limit_hit = count_q >= cfg.max_iterations;
	assign above_thr = a_q > threshold_fx(cfg.escape_threshold);
	assign in_acc    = pnt.valid && pnt.ready;

	// one saturating add or subtract per cycle
	assign sum65 = op_sub ? ({op_x[63], op_x} - {op_y[63], op_y})
	                      : ({op_x[63], op_x} + {op_y[63], op_y});
	always_comb begin
		if (sum65[64] != sum65[63]) begin
			sat_res = sum65[64] ? SAT_MIN : SAT_MAX;
		end else begin
			sat_res = signed'(sum65[63:0]);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (pnt.valid) state_d = S_CHECK;
			S_CHECK: begin
				if (limit_hit || above_thr) state_d = S_DONE;
				else state_d = S_MUL_AA;
			end
			S_MUL_AA:  state_d = S_WAIT_AA;
			S_WAIT_AA: if (mul_rsp.done) state_d = S_MUL_BB;
			S_MUL_BB:  state_d = S_WAIT_BB;
			S_WAIT_BB: if (mul_rsp.done) state_d = S_MUL_AB;
			S_MUL_AB:  state_d = S_WAIT_AB;
			S_WAIT_AB: if (mul_rsp.done) state_d = S_SUB_BB;
			S_SUB_BB:  state_d = S_SUB_C;
			S_SUB_C:   state_d = S_DBL_AB;
			S_DBL_AB:  state_d = S_SUB_D;
			S_SUB_D:   state_d = S_CHECK;
			S_DONE:    if (res.ready) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		pnt.ready     = 1'b0;
		res.valid     = 1'b0;
		mul_req.start = 1'b0;
		mul_req.x     = a_q;
		mul_req.y     = a_q;
		op_x          = aa_q;
		op_y          = bb_q;
		op_sub        = 1'b1;
		case (state_q)
			S_IDLE:   pnt.ready = 1'b1;
			S_MUL_AA: mul_req.start = 1'b1;
			S_MUL_BB: begin
				mul_req.start = 1'b1;
				mul_req.x     = b_q;
				mul_req.y     = b_q;
			end
			S_MUL_AB: begin
				mul_req.start = 1'b1;
				mul_req.y     = b_q;
			end
			S_SUB_C: begin
				op_x = t_q;
				op_y = c_q;
			end
			S_DBL_AB: begin
				op_x   = ab_q;
				op_y   = ab_q;
				op_sub = 1'b0;
			end
			S_SUB_D: begin
				op_x = t_q;
				op_y = d_q;
			end
			S_DONE:   res.valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					c_q     <= from_input(pnt.point_real);
					d_q     <= from_input(pnt.point_imag);
					a_q     <= from_input(pnt.point_real);
					b_q     <= from_input(pnt.point_imag);
					count_q <= 16'd0;
				end
			end
			S_CHECK: begin
				if (limit_hit) begin
					res_count_q <= cfg.max_iterations;
					esc_q       <= 1'b0;
				end else begin
					res_count_q <= count_q;
					esc_q       <= 1'b1;
				end
			end
			S_WAIT_AA: if (mul_rsp.done) aa_q <= mul_rsp.prod;
			S_WAIT_BB: if (mul_rsp.done) bb_q <= mul_rsp.prod;
			S_WAIT_AB: if (mul_rsp.done) ab_q <= mul_rsp.prod;
			S_SUB_BB:  t_q <= sat_res;
			S_SUB_C:   a_q <= sat_res;
			S_DBL_AB:  t_q <= sat_res;
			S_SUB_D: begin
				b_q     <= sat_res;
				count_q <= count_q + 16'd1;
			end
			default: ;
		endcase
	end

	assign res.iteration_count = res_count_q & COUNT_MASK;
	assign res.escaped         = esc_q;

`ifndef NO_ASSERTIONS
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_CHECK) else $error("accepted point did not start");
	a_escape_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && esc_q) |-> res_count_q < cfg.max_iterations)
		else $error("escape step beyond limit");
	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !esc_q) |-> res_count_q == cfg.max_iterations)
		else $error("non-escape count differs from limit");
	a_done_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == S_WAIT_AA || state_q == S_WAIT_BB ||
		state_q == S_WAIT_AB)) else $error("product arrived outside a wait state");
`endif

endmodule

>>> sv/mandelbrot_escape_count.sv
// Escape-time counter for one complex point in signed Q4.28. Starting with z equal to the
// point, each step forms z*z - point with saturating 64-bit fixed-point arithmetic and tests
// the real part against the threshold register; the result is the first step whose real part
// exceeds it (escaped = 1) or the iteration limit (escaped = 0). Points are handled one at a
// time: the next point is taken once the result of the last one has been delivered. Each step
// uses the single shared 32x32 multiplier, which builds each of the three 64-bit products
// a*a, b*b and a*b from four partial products, followed by the states S_SUB_BB, S_SUB_C,
// S_DBL_AB and S_SUB_D on the shared saturating adder and a compare in S_CHECK. The
// iteration limit resets to 4096. Registers: max_iterations at byte address 0, escape_threshold
// at byte address 4.
module mandelbrot_escape_count (
	input  logic                       clk,
	input  logic                       arst_n,
	mec_point_if.sink                  point,
	mec_result_if.source               result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mec_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import mec_pkg::*;

	cfg_t     cfg;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	mec_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mec_fxmul u_fxmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	mec_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.pnt     (point),
		.res     (result),
		.cfg     (cfg),
		.mul_req (mul_req),
		.mul_rsp (mul_rsp)
	);

endmodule
